### rtl/qsp_pkg.sv
// Shared types and constants for the quicksort pivot-mode sorter.
// No dependencies; imported by qsp_urem, the sorter top and the testbench.
package qsp_pkg;

    localparam int VAL_W  = 32;
    localparam int LFSR_W = 16;
    localparam int MODE_W = 3;

    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
    localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

    localparam logic [MODE_W-1:0] MODE_RANDOM = 3'd0;
    localparam logic [MODE_W-1:0] MODE_FIRST  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LAST   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MED3   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_MED5   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_MED7   = 3'd5;

    localparam logic REG_PIVOT_MODE = 1'b0;

    typedef enum logic [22:0] {
        S_IDLE  = 23'h000001,
        S_SORT  = 23'h000002,
        S_POP   = 23'h000004,
        S_POPD  = 23'h000008,
        S_CHOOSE = 23'h000010,
        S_SEL   = 23'h000020,
        S_DRAW  = 23'h000040,
        S_DIVW  = 23'h000080,
        S_LINIT = 23'h000100,
        S_SWRA  = 23'h000200,
        S_SWRB  = 23'h000400,
        S_SWWA  = 23'h000800,
        S_SWWB  = 23'h001000,
        S_LPV   = 23'h002000,
        S_LPV2  = 23'h004000,
        S_LLOOP = 23'h008000,
        S_LCMP  = 23'h010000,
        S_LDONE = 23'h020000,
        S_PUSHA = 23'h040000,
        S_PUSHB = 23'h080000,
        S_ERD   = 23'h100000,
        S_ELD   = 23'h200000,
        S_CLR   = 23'h400000
    } state_t;

endpackage

### rtl/qsp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module qsp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/qsp_urem.sv
// Bit-serial restoring remainder unit: LFSR word modulo a range length.
// Depends on qsp_pkg for the LFSR width.
module qsp_urem
    import qsp_pkg::*;
#(
    parameter int VW = 7
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [LFSR_W-1:0] dividend,
    input  logic [VW-1:0]     divisor,
    output logic              done,
    output logic [VW-1:0]     rem
);

    localparam int CNT_W = $clog2(LFSR_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [VW-1:0]     rem_reg, rem_next;
    logic [LFSR_W-1:0] sh_reg, sh_next;
    logic [VW-1:0]     dv_reg, dv_next;
    logic [VW:0]       trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        dv_next   = dv_reg;
        trial     = {rem_reg, sh_reg[LFSR_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(LFSR_W);
            rem_next  = '0;
            sh_next   = dividend;
            dv_next   = divisor;
        end
        else if (busy_reg)
        begin
            // shift in one dividend bit, subtract when it fits
            if (trial >= {1'b0, dv_reg})
            begin
                trial = trial - {1'b0, dv_reg};
            end
            rem_next = trial[VW-1:0];
            sh_next  = {sh_reg[LFSR_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        dv_reg  <= dv_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

### rtl/quicksort_pivot_modes.sv
// Set sorter: loads a set, sorts it by quicksort with a selectable pivot rule, emits it.
// Depends on qsp_pkg, qsp_ram (element store, range stack) and qsp_urem.
//
// Usage:
//   Input stream (s_*): one signed 32-bit value per transaction; tlast marks
//   the final value of a set. Values beyond SIZE are dropped and flagged.
//   Loading takes one cycle per transaction. After the last transaction the
//   block sorts in place and s_tready stays low until the whole set has been
//   handed to the output register.
//   Sorting runs on one element-store port pair: a Lomuto compare reads in
//   S_LLOOP and tests in S_LCMP, a swap runs S_SWRA, S_SWRB, S_SWWA, S_SWWB;
//   a random draw waits on the bit-serial remainder unit.
//   Output stream (m_*): the sorted set, ascending, tlast on the final value,
//   tuser = overflow for the set. Each result is read (S_ERD) and then loaded
//   (S_ELD); a stall holds the output register and the sequencer.
//   APB: register 0 = pivot_mode (0 random, 1 first, 2 last, 3/4/5 median
//   of 3/5/7 window); write only while idle.
//   Reset: empty set, pivot_mode 3, LFSR seeded; no clearing pass needed.
module quicksort_pivot_modes
    import qsp_pkg::*;
#(
    parameter int SIZE = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [VAL_W-1:0] s_tdata,   // [31:0] value_in
    input  logic             s_tlast,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [VAL_W-1:0] m_tdata,   // [31:0] value_out
    output logic             m_tlast,
    output logic             m_tuser,   // [0] overflow
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int IW = (SIZE > 1) ? $clog2(SIZE) : 1;
    localparam int CW = $clog2(SIZE + 1);
    localparam int SW = 2 * IW;
    localparam int WW = IW + 4;

    state_t            state_reg, state_next, ret_reg, ret_next;
    logic [CW-1:0]     cnt_reg, cnt_next, sp_reg, sp_next;
    logic [LFSR_W-1:0] lfsr_reg, lfsr_next, lfsr_adv;
    logic              drop_reg, drop_next;
    logic [MODE_W-1:0] mode_reg, mode_next;
    logic              sel_reg, sel_next;
    logic              ovalid_reg, ovalid_next;

    logic [IW-1:0] rlo_reg, rlo_next, rhi_reg, rhi_next;
    logic [IW-1:0] llo_reg, llo_next, lhi_reg, lhi_next;
    logic [IW-1:0] slo_reg, slo_next, shi_reg, shi_next, sk_reg, sk_next;
    logic [IW-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [IW-1:0] piv_reg, piv_next, sa_reg, sa_next, sb_reg, sb_next;
    logic [IW-1:0] pal_reg, pal_next, pah_reg, pah_next;
    logic [IW-1:0] pbl_reg, pbl_next, pbh_reg, pbh_next;
    logic          pao_reg, pao_next, pbo_reg, pbo_next;
    logic [VAL_W-1:0] pv_reg, pv_next, ta_reg, ta_next;
    logic [VAL_W-1:0] od_reg, od_next;
    logic             ol_reg, ol_next, ou_reg, ou_next;

    logic             e_we;
    logic [IW-1:0]    e_waddr, e_raddr;
    logic [VAL_W-1:0] e_wdata, e_rdata;
    logic             st_we;
    logic [IW-1:0]    st_waddr, st_raddr;
    logic [SW-1:0]    st_wdata, st_rdata;

    logic          div_start, div_done;
    logic [CW-1:0] div_divisor, div_rem;

    logic [IW-1:0] last_idx, sel_tgt, p_m1, p_p1;
    logic          lok, rok;
    logic [WW-1:0] w_len, w_sum, w_t, w_b, w_e;
    logic [IW-1:0] wb_i, we_i;

    qsp_ram #(.WIDTH(VAL_W), .DEPTH(SIZE)) u_store (
        .clk   (clk),
        .we    (e_we),
        .waddr (e_waddr),
        .wdata (e_wdata),
        .raddr (e_raddr),
        .rdata (e_rdata)
    );

    qsp_ram #(.WIDTH(SW), .DEPTH(SIZE)) u_stack (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    qsp_urem #(.VW(CW)) u_urem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (lfsr_adv),
        .divisor  (div_divisor),
        .done     (div_done),
        .rem      (div_rem)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = od_reg;
    assign m_tlast  = ol_reg;
    assign m_tuser  = ou_reg;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_PIVOT_MODE) ? {29'd0, mode_reg} : 32'd0;

    assign lfsr_adv = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ LFSR_TAPS) : (lfsr_reg >> 1);
    assign last_idx = IW'(cnt_reg - 1'b1);
    assign sel_tgt  = slo_reg + sk_reg;
    assign p_m1     = i_reg - 1'b1;
    assign p_p1     = i_reg + 1'b1;
    assign lok      = (i_reg - rlo_reg) > IW'(1);
    assign rok      = (rhi_reg - i_reg) > IW'(1);

    // centred window, clipped to the current range
    always_comb
    begin
        case (mode_reg)
            MODE_MED5: w_len = WW'(5);
            MODE_MED7: w_len = WW'(7);
            default:   w_len = WW'(3);
        endcase
        w_sum = WW'(rlo_reg) + WW'(rhi_reg);
        w_t   = w_sum + WW'(1) - w_len;
        w_b   = w_t[WW-1] ? WW'(rlo_reg) : (w_t >> 1);
        w_e   = (w_sum + w_len - WW'(1)) >> 1;
        wb_i  = (w_b < WW'(rlo_reg)) ? rlo_reg : w_b[IW-1:0];
        we_i  = (w_e > WW'(rhi_reg)) ? rhi_reg : w_e[IW-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        cnt_next   = cnt_reg;
        sp_next    = sp_reg;
        lfsr_next  = lfsr_reg;
        drop_next  = drop_reg;
        mode_next  = mode_reg;
        sel_next   = sel_reg;
        rlo_next = rlo_reg;  rhi_next = rhi_reg;
        llo_next = llo_reg;  lhi_next = lhi_reg;
        slo_next = slo_reg;  shi_next = shi_reg;  sk_next = sk_reg;
        i_next   = i_reg;    j_next   = j_reg;    k_next  = k_reg;
        piv_next = piv_reg;  sa_next  = sa_reg;   sb_next = sb_reg;
        pal_next = pal_reg;  pah_next = pah_reg;  pao_next = pao_reg;
        pbl_next = pbl_reg;  pbh_next = pbh_reg;  pbo_next = pbo_reg;
        pv_next  = pv_reg;   ta_next  = ta_reg;
        od_next  = od_reg;   ol_next  = ol_reg;   ou_next = ou_reg;
        ovalid_next = ovalid_reg;

        e_we = 1'b0;  e_waddr = cnt_reg[IW-1:0];  e_wdata = s_tdata;  e_raddr = k_reg;
        st_we = 1'b0; st_waddr = sp_reg[IW-1:0];  st_wdata = {pal_reg, pah_reg};
        st_raddr = IW'(sp_reg - 1'b1);
        div_start = 1'b0;
        div_divisor = CW'(lhi_reg - llo_reg) + CW'(1);

        if (ovalid_reg && m_tready)
        begin
            ovalid_next = 1'b0;
        end

        if (psel && penable && pwrite && paddr[2] == REG_PIVOT_MODE)
        begin
            mode_next = pwdata[MODE_W-1:0];
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (cnt_reg < CW'(SIZE))
                    begin
                        e_we     = 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                    if (s_tlast)
                    begin
                        state_next = S_SORT;
                    end
                end
            end
            S_SORT:
            begin
                sel_next = 1'b0;
                if (cnt_reg > CW'(1))
                begin
                    st_we    = 1'b1;
                    st_waddr = '0;
                    st_wdata = {{IW{1'b0}}, last_idx};
                    sp_next  = CW'(1);
                end
                else
                begin
                    sp_next = '0;
                end
                state_next = S_POP;
            end
            S_POP:
            begin
                if (sp_reg == '0)
                begin
                    k_next     = '0;
                    state_next = S_ERD;
                end
                else
                begin
                    sp_next    = sp_reg - 1'b1;
                    state_next = S_POPD;
                end
            end
            S_POPD:
            begin
                rlo_next = st_rdata[SW-1:IW];
                rhi_next = st_rdata[IW-1:0];
                if (st_rdata[SW-1:IW] >= st_rdata[IW-1:0]
                    || CW'(st_rdata[IW-1:0]) >= cnt_reg)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    state_next = S_CHOOSE;
                end
            end
            S_CHOOSE:
            begin
                llo_next = rlo_reg;
                lhi_next = rhi_reg;
                case (mode_reg)
                    MODE_RANDOM:
                    begin
                        state_next = S_DRAW;
                    end
                    MODE_LAST:
                    begin
                        piv_next   = rhi_reg;
                        state_next = S_LINIT;
                    end
                    MODE_MED3, MODE_MED5, MODE_MED7:
                    begin
                        slo_next   = wb_i;
                        shi_next   = we_i;
                        sk_next    = (we_i - wb_i) >> 1;
                        sel_next   = 1'b1;
                        state_next = S_SEL;
                    end
                    default:
                    begin
                        piv_next   = rlo_reg;
                        state_next = S_LINIT;
                    end
                endcase
            end
            S_SEL:
            begin
                if (slo_reg >= shi_reg)
                begin
                    // median found: partition the sort range around it
                    piv_next   = slo_reg;
                    sel_next   = 1'b0;
                    llo_next   = rlo_reg;
                    lhi_next   = rhi_reg;
                    state_next = S_LINIT;
                end
                else
                begin
                    llo_next   = slo_reg;
                    lhi_next   = shi_reg;
                    state_next = S_DRAW;
                end
            end
            S_DRAW:
            begin
                lfsr_next  = lfsr_adv;
                div_start  = 1'b1;
                state_next = S_DIVW;
            end
            S_DIVW:
            begin
                if (div_done)
                begin
                    piv_next   = llo_reg + div_rem[IW-1:0];
                    state_next = S_LINIT;
                end
            end
            S_LINIT:
            begin
                sa_next    = piv_reg;
                sb_next    = lhi_reg;
                ret_next   = S_LPV;
                state_next = S_SWRA;
            end
            S_SWRA:
            begin
                e_raddr    = sa_reg;
                state_next = S_SWRB;
            end
            S_SWRB:
            begin
                e_raddr    = sb_reg;
                ta_next    = e_rdata;
                state_next = S_SWWA;
            end
            S_SWWA:
            begin
                e_we       = 1'b1;
                e_waddr    = sa_reg;
                e_wdata    = e_rdata;
                state_next = S_SWWB;
            end
            S_SWWB:
            begin
                e_we       = 1'b1;
                e_waddr    = sb_reg;
                e_wdata    = ta_reg;
                state_next = ret_reg;
            end
            S_LPV:
            begin
                e_raddr    = lhi_reg;
                state_next = S_LPV2;
            end
            S_LPV2:
            begin
                pv_next    = e_rdata;
                i_next     = llo_reg;
                j_next     = llo_reg;
                state_next = S_LLOOP;
            end
            S_LLOOP:
            begin
                e_raddr = j_reg;
                if (j_reg == lhi_reg)
                begin
                    sa_next    = i_reg;
                    sb_next    = lhi_reg;
                    ret_next   = S_LDONE;
                    state_next = S_SWRA;
                end
                else
                begin
                    state_next = S_LCMP;
                end
            end
            S_LCMP:
            begin
                j_next = j_reg + 1'b1;
                if ($signed(e_rdata) <= $signed(pv_reg))
                begin
                    sa_next    = i_reg;
                    sb_next    = j_reg;
                    i_next     = i_reg + 1'b1;
                    ret_next   = S_LLOOP;
                    state_next = S_SWRA;
                end
                else
                begin
                    state_next = S_LLOOP;
                end
            end
            S_LDONE:
            begin
                if (sel_reg)
                begin
                    if (i_reg == sel_tgt)
                    begin
                        piv_next   = i_reg;
                        sel_next   = 1'b0;
                        llo_next   = rlo_reg;
                        lhi_next   = rhi_reg;
                        state_next = S_LINIT;
                    end
                    else if (i_reg < sel_tgt)
                    begin
                        sk_next    = sel_tgt - i_reg - 1'b1;
                        slo_next   = p_p1;
                        state_next = S_SEL;
                    end
                    else
                    begin
                        shi_next   = p_m1;
                        state_next = S_SEL;
                    end
                end
                else
                begin
                    // push the larger part first so the smaller one is sorted next
                    if ((i_reg - rlo_reg) > (rhi_reg - i_reg))
                    begin
                        pal_next = rlo_reg; pah_next = p_m1;    pao_next = lok;
                        pbl_next = p_p1;    pbh_next = rhi_reg; pbo_next = rok;
                    end
                    else
                    begin
                        pal_next = p_p1;    pah_next = rhi_reg; pao_next = rok;
                        pbl_next = rlo_reg; pbh_next = p_m1;    pbo_next = lok;
                    end
                    state_next = S_PUSHA;
                end
            end
            S_PUSHA:
            begin
                if (pao_reg && sp_reg < CW'(SIZE))
                begin
                    st_we   = 1'b1;
                    sp_next = sp_reg + 1'b1;
                end
                state_next = S_PUSHB;
            end
            S_PUSHB:
            begin
                st_wdata = {pbl_reg, pbh_reg};
                if (pbo_reg && sp_reg < CW'(SIZE))
                begin
                    st_we   = 1'b1;
                    sp_next = sp_reg + 1'b1;
                end
                state_next = S_POP;
            end
            S_ERD:
            begin
                state_next = S_ELD;
            end
            S_ELD:
            begin
                if (!ovalid_reg || m_tready)
                begin
                    ovalid_next = 1'b1;
                    od_next     = e_rdata;
                    ol_next     = (k_reg == last_idx);
                    ou_next     = drop_reg;
                    if (k_reg == last_idx)
                    begin
                        state_next = S_CLR;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_ERD;
                    end
                end
            end
            S_CLR:
            begin
                cnt_next   = '0;
                sp_next    = '0;
                drop_next  = 1'b0;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ret_reg    <= S_IDLE;
            cnt_reg    <= '0;
            sp_reg     <= '0;
            lfsr_reg   <= LFSR_SEED;
            drop_reg   <= 1'b0;
            mode_reg   <= MODE_MED3;
            sel_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ret_reg    <= ret_next;
            cnt_reg    <= cnt_next;
            sp_reg     <= sp_next;
            lfsr_reg   <= lfsr_next;
            drop_reg   <= drop_next;
            mode_reg   <= mode_next;
            sel_reg    <= sel_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rlo_reg <= rlo_next;  rhi_reg <= rhi_next;
        llo_reg <= llo_next;  lhi_reg <= lhi_next;
        slo_reg <= slo_next;  shi_reg <= shi_next;  sk_reg <= sk_next;
        i_reg   <= i_next;    j_reg   <= j_next;    k_reg  <= k_next;
        piv_reg <= piv_next;  sa_reg  <= sa_next;   sb_reg <= sb_next;
        pal_reg <= pal_next;  pah_reg <= pah_next;  pao_reg <= pao_next;
        pbl_reg <= pbl_next;  pbh_reg <= pbh_next;  pbo_reg <= pbo_next;
        pv_reg  <= pv_next;   ta_reg  <= ta_next;
        od_reg  <= od_next;   ol_reg  <= ol_next;   ou_reg <= ou_next;
    end

    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= CW'(SIZE))
        else $error("range stack pointer beyond depth");

    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIVW)
        else $error("remainder finished outside a random draw");

    a_part_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_LCMP |-> (i_reg <= j_reg && j_reg < lhi_reg))
        else $error("partition indexes out of order");

endmodule

### verif/quicksort_pivot_modes_tb.sv
// Testbench for quicksort_pivot_modes: streams signed sets, checks sorted output per set.
// Depends on qsp_pkg and the quicksort_pivot_modes RTL; self-contained otherwise.
module quicksort_pivot_modes_tb;
    import qsp_pkg::*;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             last;
    } elem_t;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             last;
        logic             ovf;
    } sorted_t;

    localparam int CAP = 64;

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [VAL_W-1:0] s_tdata;
    logic             s_tlast;
    logic             m_tvalid;
    logic             m_tready;
    logic [VAL_W-1:0] m_tdata;
    logic             m_tlast;
    logic             m_tuser;
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [2:0]       paddr;
    logic [31:0]      pwdata;
    logic [31:0]      prdata;
    logic             pready;

    quicksort_pivot_modes dut (.*);

    elem_t   pending_q[$];
    sorted_t sorted_q[$];
    int      errors;
    int      send_gap;
    int      recv_gap;
    int      hold_cycles;
    bit      tx_pause;

    // predictor state
    logic signed [VAL_W-1:0] store[CAP];
    int                      count;
    logic [5:0]              lo_stack[CAP];
    logic [5:0]              hi_stack[CAP];
    int                      sp;
    logic [LFSR_W-1:0]       lfsr;
    bit                      dropped;
    logic [MODE_W-1:0]       mode;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic int next_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic void swap_elems(int a, int b);
        logic signed [VAL_W-1:0] t;
        t = store[a];
        store[a] = store[b];
        store[b] = t;
    endfunction

    function automatic int draw_index(int lo, int hi);
        logic b;
        b = lfsr[0];
        lfsr = lfsr >> 1;
        if (b) lfsr = lfsr ^ LFSR_TAPS;
        return lo + int'(lfsr) % (hi - lo + 1);
    endfunction

    function automatic int partition(int lo, int hi, int piv);
        int i;
        i = lo;
        swap_elems(piv, hi);
        for (int j = lo; j < hi; j++)
        begin
            if (store[j] <= store[hi])
            begin
                swap_elems(i, j);
                i++;
            end
        end
        swap_elems(i, hi);
        return i;
    endfunction

    function automatic int select_kth(int lo, int hi, int k);
        int p;
        forever
        begin
            if (lo >= hi) return lo;
            p = partition(lo, hi, draw_index(lo, hi));
            if (p == lo + k) return p;
            if (p < lo + k)
            begin
                k = lo + k - p - 1;
                lo = p + 1;
            end
            else
                hi = p - 1;
        end
    endfunction

    function automatic int window_median(int lo, int hi, int w);
        int wb;
        int we;
        wb = (hi + lo - w + 1) / 2;
        we = (hi + lo + w - 1) / 2;
        if (wb < lo) wb = lo;
        if (we > hi) we = hi;
        return select_kth(wb, we, (we - wb) / 2);
    endfunction

    function automatic int pick_pivot(int lo, int hi);
        case (mode)
            MODE_RANDOM: return draw_index(lo, hi);
            MODE_LAST:   return hi;
            MODE_MED3:   return window_median(lo, hi, 3);
            MODE_MED5:   return window_median(lo, hi, 5);
            MODE_MED7:   return window_median(lo, hi, 7);
            default:     return lo;
        endcase
    endfunction

    function automatic void push_range(int lo, int hi);
        if (lo >= hi || sp >= CAP) return;
        lo_stack[sp] = lo[5:0];
        hi_stack[sp] = hi[5:0];
        sp++;
    endfunction

    function automatic void sort_set();
        int lo;
        int hi;
        int p;
        sp = 0;
        push_range(0, count - 1);
        while (sp > 0)
        begin
            sp--;
            lo = lo_stack[sp];
            hi = hi_stack[sp];
            if (lo >= hi || hi >= count) continue;
            p = partition(lo, hi, pick_pivot(lo, hi));
            if (p - lo > hi - p)
            begin
                push_range(lo, p - 1);
                push_range(p + 1, hi);
            end
            else
            begin
                push_range(p + 1, hi);
                push_range(lo, p - 1);
            end
        end
    endfunction

    function automatic void load_element(elem_t e);
        sorted_t s;
        if (count < CAP)
        begin
            store[count] = e.value;
            count++;
        end
        else
            dropped = 1'b1;
        if (!e.last) return;
        sort_set();
        for (int k = 0; k < count; k++)
        begin
            s.value = store[k];
            s.last  = (k + 1 == count);
            s.ovf   = dropped;
            sorted_q.push_back(s);
        end
        count = 0;
        sp = 0;
        dropped = 1'b0;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                load_element(elem_t'{s_tdata, s_tlast});
                void'(pending_q.pop_front());
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (tx_pause || pending_q.size() == 0)
                    s_tvalid <= 1'b0;
                else
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_q[0].value;
                    s_tlast  <= pending_q[0].last;
                    send_gap <= next_gap();
                end
            end
        end
    end

    // monitor and receiver
    always @(posedge clk or negedge rst_n)
    begin
        sorted_t exp_r;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            recv_gap <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (sorted_q.size() == 0)
                begin
                    $error("unexpected result value=%0h", m_tdata);
                    errors++;
                end
                else
                begin
                    exp_r = sorted_q.pop_front();
                    if (m_tdata !== exp_r.value)
                    begin
                        $error("value_out exp %0d got %0d", $signed(exp_r.value),
                               $signed(m_tdata));
                        errors++;
                    end
                    if (m_tlast !== exp_r.last)
                    begin
                        $error("last_out exp %0b got %0b", exp_r.last, m_tlast);
                        errors++;
                    end
                    if (m_tuser !== exp_r.ovf)
                    begin
                        $error("overflow exp %0b got %0b", exp_r.ovf, m_tuser);
                        errors++;
                    end
                end
            end
            if (hold_cycles > 0)
                m_tready <= 1'b0;
            else if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                recv_gap <= next_gap();
            end
        end
    end

    // long receiver hold-off, counted here
    always @(posedge clk)
        if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == 3'd4 * REG_PIVOT_MODE) mode = data[MODE_W-1:0];
    endtask

    task automatic wait_drained();
        while (pending_q.size() > 0 || sorted_q.size() > 0) @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    function automatic logic [VAL_W-1:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000 + $urandom_range(0, 3);
            1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            2: return $urandom_range(0, 7) - 4;
            3: return $urandom_range(0, 40);
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_set(input int n, input bit few_vals);
        elem_t e;
        logic [VAL_W-1:0] v;
        for (int i = 0; i < n; i++)
        begin
            v = few_vals ? VAL_W'($urandom_range(0, 3)) : rand_value();
            e.value = v;
            e.last  = (i == n - 1);
            pending_q.push_back(e);
        end
    endtask

    initial
    begin
        logic [MODE_W-1:0] modes[8];
        int n;
        int sent;
        errors = 0;
        hold_cycles = 0;
        tx_pause = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        rst_n = 1'b0;
        count = 0;
        sp = 0;
        lfsr = LFSR_SEED;
        dropped = 1'b0;
        mode = MODE_MED3;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, single element, duplicates, reset mode
        pending_q.push_back(elem_t'{32'h8000_0000, 1'b0});
        pending_q.push_back(elem_t'{32'h7FFF_FFFF, 1'b0});
        pending_q.push_back(elem_t'{32'hFFFF_FFFF, 1'b0});
        pending_q.push_back(elem_t'{32'h0000_0000, 1'b0});
        pending_q.push_back(elem_t'{32'h0000_0001, 1'b1});
        pending_q.push_back(elem_t'{32'h1234_5678, 1'b1});
        pending_q.push_back(elem_t'{32'h5, 1'b0});
        pending_q.push_back(elem_t'{32'h5, 1'b0});
        pending_q.push_back(elem_t'{32'h5, 1'b1});
        wait_drained();

        // every mode incl. unused 6 and 7, one small set each
        modes = '{MODE_RANDOM, MODE_FIRST, MODE_LAST, MODE_MED3, MODE_MED5,
                  MODE_MED7, 3'd6, 3'd7};
        for (int m = 0; m < 8; m++)
        begin
            apb_write(3'd4 * REG_PIVOT_MODE, 32'(modes[m]));
            queue_set(m < 6 ? 9 : 3, 1'b0);
            wait_drained();
        end

        // overflow: 70 items into a 64-entry store, receiver held off meanwhile
        apb_write(3'd4 * REG_PIVOT_MODE, 32'(MODE_RANDOM));
        hold_cycles = 3000;
        queue_set(70, 1'b0);
        queue_set(4, 1'b0);
        wait_drained();

        // random sets across modes; one pause until drained per mode
        sent = 0;
        while (sent < 300)
        begin
            apb_write(3'd4 * REG_PIVOT_MODE, $urandom_range(0, 7));
            for (int s = 0; s < 6; s++)
            begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 66)
                                                : $urandom_range(1, 14);
                queue_set(n, $urandom_range(0, 3) == 0);
                sent += n;
            end
            if ($urandom_range(0, 3) == 0)
            begin
                tx_pause = 1'b1;
                repeat ($urandom_range(20, 200)) @(posedge clk);
                tx_pause = 1'b0;
            end
            wait_drained();
        end

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("== FAIL ==");
        $finish;
    end
endmodule

### filelist.f
rtl/qsp_pkg.sv
rtl/qsp_ram.sv
rtl/qsp_urem.sv
rtl/quicksort_pivot_modes.sv
verif/quicksort_pivot_modes_tb.sv
